### src/cnr_pkg.sv
// Shared types, codes and saturating arithmetic helpers for the cubic root solver.
package cnr_pkg;

    localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_VAL = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic [1:0] CFG_TOLERANCE  = 2'd0;
    localparam logic [1:0] CFG_STEP_LIMIT = 2'd1;
    localparam logic [1:0] CFG_FAIL       = 2'd2;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_LIMIT_OK  = 2'd1;
    localparam logic [1:0] ST_FAILED    = 2'd2;
    localparam logic [1:0] ST_FLAT      = 2'd3;

    localparam logic [31:0] TOL_RESET   = 32'd28147;
    localparam logic [15:0] LIMIT_RESET = 16'd10000;
    localparam logic [31:0] FAIL_RESET  = 32'd281474977;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_MWAIT,
        S_CHECK,
        S_DIV,
        S_DWAIT,
        S_OUT
    } state_t;

    // product sequence: polynomial terms first, then derivative terms
    typedef enum logic [2:0] {
        OP_X2,
        OP_X3,
        OP_M1,
        OP_M2,
        OP_M3,
        OP_T,
        OP_U
    } op_t;

    function automatic logic [63:0] magnitude(input logic [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    function automatic logic [63:0] apply_sign(input logic [63:0] mag, input logic neg,
                                               input logic ovf);
        logic [63:0] res;
        if (neg) begin
            res = (ovf || mag > MIN_VAL) ? MIN_VAL : (64'd0 - mag);
        end
        else begin
            res = (ovf || mag > MAX_VAL) ? MAX_VAL : mag;
        end
        return res;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (((a[63] ^ s[63]) & (b[63] ^ s[63])) == 1'b1) begin
            s = a[63] ? MIN_VAL : MAX_VAL;
        end
        return s;
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a - b;
        if (((a[63] ^ b[63]) & (a[63] ^ s[63])) == 1'b1) begin
            s = a[63] ? MIN_VAL : MAX_VAL;
        end
        return s;
    endfunction

endpackage

### src/cubic_newton_root_solver_top.sv
// Top level: Newton-Raphson sequencer for a cubic over a shared multiplier and divider.
//
// Raise start with the four coefficients and a starting guess (signed fixed point,
// FRAC_BITS fraction bits); the item transfers on the edge where start is high and
// busy is low. busy stays high until the result is out. Exactly one result per item:
// done is high for one cycle with root, residual, steps_taken and status, and the
// receiver takes it in that cycle; it cannot stall the block.
// Each polynomial evaluation uses five products and each derivative two, all on
// one shared multiplier built from one 32x32 multiplier; each step adds one
// quotient from a bit-serial divider. busy drops in the done cycle, so the next
// item can already transfer in that cycle.
// The config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes tolerance,
// step_limit and fail_threshold; ready is always high. Write only while idle.
// Reset returns the sequencer to idle and the config registers to defaults.
module cubic_newton_root_solver_top #(
    parameter int FRAC_BITS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] coef_zero,
    input  logic [63:0] coef_one,
    input  logic [63:0] coef_two,
    input  logic [63:0] coef_three,
    input  logic [63:0] start_guess,
    output logic        done,
    output logic [63:0] root,
    output logic [63:0] residual,
    output logic [15:0] steps_taken,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cnr_pkg::state_t state_reg, state_next;
    cnr_pkg::op_t    op_reg, op_next;

    logic [31:0] tol_reg;
    logic [15:0] limit_reg;
    logic [31:0] fail_reg;

    logic [63:0] c0_reg, c1_reg, c2_reg, c3_reg;
    logic [63:0] x_reg, x_next;
    logic [63:0] x2_reg, x2_next;
    logic [63:0] x3_reg, x3_next;
    logic [63:0] s_reg, s_next;
    logic [63:0] err_reg, err_next;
    logic [63:0] dp_reg, dp_next;
    logic [15:0] count_reg, count_next;
    logic        flat_reg, flat_next;

    logic        done_reg;
    logic [63:0] root_reg, residual_reg;
    logic [15:0] steps_reg;
    logic [1:0]  status_reg;

    logic        mul_start, mul_done;
    logic [63:0] mul_a, mul_b, mul_res;
    logic        div_start, div_done;
    logic [63:0] div_res;

    logic [63:0] dp_val;
    logic        more;

    cnr_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    cnr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (err_reg),
        .den    (dp_reg),
        .done   (div_done),
        .result (div_res)
    );

    always_comb
    begin
        dp_val = cnr_pkg::sat_add(s_reg,
                     cnr_pkg::sat_add(cnr_pkg::sat_add(mul_res, mul_res), mul_res));
        more   = (cnr_pkg::magnitude(err_reg) > {32'd0, tol_reg}) && (count_reg < limit_reg);
    end

    always_comb
    begin
        unique case (op_reg)
            cnr_pkg::OP_X2: begin mul_a = x_reg;  mul_b = x_reg;  end
            cnr_pkg::OP_X3: begin mul_a = x2_reg; mul_b = x_reg;  end
            cnr_pkg::OP_M1: begin mul_a = c1_reg; mul_b = x_reg;  end
            cnr_pkg::OP_M2: begin mul_a = c2_reg; mul_b = x2_reg; end
            cnr_pkg::OP_M3: begin mul_a = c3_reg; mul_b = x3_reg; end
            cnr_pkg::OP_T:  begin mul_a = c2_reg; mul_b = x_reg;  end
            cnr_pkg::OP_U:  begin mul_a = c3_reg; mul_b = x2_reg; end
            default:        begin mul_a = x_reg;  mul_b = x_reg;  end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cnr_pkg::S_IDLE:  if (start) state_next = cnr_pkg::S_MUL;
            cnr_pkg::S_MUL:   state_next = cnr_pkg::S_MWAIT;
            cnr_pkg::S_MWAIT: begin
                if (mul_done) begin
                    if (op_reg == cnr_pkg::OP_M3) begin
                        state_next = cnr_pkg::S_CHECK;
                    end
                    else if (op_reg == cnr_pkg::OP_U) begin
                        state_next = (dp_val == 64'd0) ? cnr_pkg::S_OUT : cnr_pkg::S_DIV;
                    end
                    else begin
                        state_next = cnr_pkg::S_MUL;
                    end
                end
            end
            cnr_pkg::S_CHECK: state_next = more ? cnr_pkg::S_MUL : cnr_pkg::S_OUT;
            cnr_pkg::S_DIV:   state_next = cnr_pkg::S_DWAIT;
            cnr_pkg::S_DWAIT: if (div_done) state_next = cnr_pkg::S_MUL;
            cnr_pkg::S_OUT:   state_next = cnr_pkg::S_IDLE;
            default:          state_next = cnr_pkg::S_IDLE;
        endcase
    end

    // outputs to the shared units, plus busy and cfg_ready
    always_comb
    begin
        mul_start = (state_reg == cnr_pkg::S_MUL);
        div_start = (state_reg == cnr_pkg::S_DIV);
        busy      = (state_reg != cnr_pkg::S_IDLE);
        cfg_ready = 1'b1;
    end

    // datapath next values
    always_comb
    begin
        op_next    = op_reg;
        x_next     = x_reg;
        x2_next    = x2_reg;
        x3_next    = x3_reg;
        s_next     = s_reg;
        err_next   = err_reg;
        dp_next    = dp_reg;
        count_next = count_reg;
        flat_next  = flat_reg;
        unique case (state_reg)
            cnr_pkg::S_IDLE: begin
                op_next    = cnr_pkg::OP_X2;
                x_next     = start_guess;
                count_next = 16'd0;
                flat_next  = 1'b0;
            end
            cnr_pkg::S_MWAIT: begin
                if (mul_done) begin
                    unique case (op_reg)
                        cnr_pkg::OP_X2: begin
                            x2_next = mul_res;
                            op_next = cnr_pkg::OP_X3;
                        end
                        cnr_pkg::OP_X3: begin
                            x3_next = mul_res;
                            op_next = cnr_pkg::OP_M1;
                        end
                        cnr_pkg::OP_M1: begin
                            s_next  = cnr_pkg::sat_add(c0_reg, mul_res);
                            op_next = cnr_pkg::OP_M2;
                        end
                        cnr_pkg::OP_M2: begin
                            s_next  = cnr_pkg::sat_add(s_reg, mul_res);
                            op_next = cnr_pkg::OP_M3;
                        end
                        cnr_pkg::OP_M3: begin
                            err_next = cnr_pkg::sat_add(s_reg, mul_res);
                            op_next  = cnr_pkg::OP_T;
                        end
                        cnr_pkg::OP_T: begin
                            s_next  = cnr_pkg::sat_add(c1_reg,
                                          cnr_pkg::sat_add(mul_res, mul_res));
                            op_next = cnr_pkg::OP_U;
                        end
                        cnr_pkg::OP_U: begin
                            dp_next   = dp_val;
                            flat_next = (dp_val == 64'd0);
                            op_next   = cnr_pkg::OP_X2;
                        end
                        default: op_next = cnr_pkg::OP_X2;
                    endcase
                end
            end
            cnr_pkg::S_DWAIT: begin
                if (div_done) begin
                    x_next     = cnr_pkg::sat_sub(x_reg, div_res);
                    count_next = count_reg + 16'd1;
                    op_next    = cnr_pkg::OP_X2;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= cnr_pkg::S_IDLE;
            op_reg    <= cnr_pkg::OP_X2;
            done_reg  <= 1'b0;
            tol_reg   <= cnr_pkg::TOL_RESET;
            limit_reg <= cnr_pkg::LIMIT_RESET;
            fail_reg  <= cnr_pkg::FAIL_RESET;
            count_reg <= 16'd0;
            flat_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            count_reg <= count_next;
            flat_reg  <= flat_next;
            done_reg  <= (state_reg == cnr_pkg::S_OUT);
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    cnr_pkg::CFG_TOLERANCE:  tol_reg   <= cfg_data;
                    cnr_pkg::CFG_STEP_LIMIT: limit_reg <= cfg_data[15:0];
                    cnr_pkg::CFG_FAIL:       fail_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == cnr_pkg::S_IDLE && start) begin
            c0_reg <= coef_zero;
            c1_reg <= coef_one;
            c2_reg <= coef_two;
            c3_reg <= coef_three;
        end
        x_reg   <= x_next;
        x2_reg  <= x2_next;
        x3_reg  <= x3_next;
        s_reg   <= s_next;
        err_reg <= err_next;
        dp_reg  <= dp_next;
        if (state_reg == cnr_pkg::S_OUT) begin
            root_reg     <= x_reg;
            residual_reg <= err_reg;
            steps_reg    <= count_reg;
            if (flat_reg) begin
                status_reg <= cnr_pkg::ST_FLAT;
            end
            else if (count_reg >= limit_reg) begin
                status_reg <= (cnr_pkg::magnitude(err_reg) > {32'd0, fail_reg})
                              ? cnr_pkg::ST_FAILED : cnr_pkg::ST_LIMIT_OK;
            end
            else begin
                status_reg <= cnr_pkg::ST_CONVERGED;
            end
        end
    end

    assign done        = done_reg;
    assign root        = root_reg;
    assign residual    = residual_reg;
    assign steps_taken = steps_reg;
    assign status      = status_reg;

endmodule

### src/cnr_mul.sv
// Fixed-point saturating multiplier built from one 32x32 multiplier, one partial product at a time.
module cnr_mul #(
    parameter int FRAC_BITS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] result
);

    logic [63:0]  ma_reg, mb_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [1:0]   cnt_reg;
    logic         run_reg, fin_reg, done_reg;
    logic [63:0]  result_reg;

    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [127:0] pp_shift;
    logic [63:0]  res_mag;
    logic         ovf;

    always_comb
    begin
        pa = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        pb = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        pp = {32'd0, pa} * {32'd0, pb};
        // place the partial product by the weight of its two halves
        case ({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]})
            2'd0:    pp_shift = {64'd0, pp};
            2'd1:    pp_shift = {32'd0, pp, 32'd0};
            default: pp_shift = {pp, 64'd0};
        endcase
        res_mag = acc_reg[FRAC_BITS +: 64];
        ovf     = |acc_reg[127:64 + FRAC_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= 2'd0;
            end
            else if (run_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            ma_reg  <= cnr_pkg::magnitude(a);
            mb_reg  <= cnr_pkg::magnitude(b);
            neg_reg <= a[63] ^ b[63];
            acc_reg <= 128'd0;
        end
        else if (run_reg) begin
            acc_reg <= acc_reg + pp_shift;
        end
        if (fin_reg) begin
            result_reg <= cnr_pkg::apply_sign(res_mag, neg_reg, ovf);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### src/cnr_div.sv
// Fixed-point saturating divider, restoring, one quotient bit per cycle.
module cnr_div #(
    parameter int FRAC_BITS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] result
);

    logic [127:0] dvd_reg;
    logic [63:0]  md_reg, r_reg, q_reg;
    logic         neg_reg, ovf_reg;
    logic [6:0]   cnt_reg;
    logic         run_reg, fin_reg, done_reg;
    logic [63:0]  result_reg;

    logic [64:0]  r_shift;
    logic         take;

    always_comb
    begin
        r_shift = {r_reg, dvd_reg[127]};
        take    = r_shift >= {1'b0, md_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= 7'd0;
            end
            else if (run_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd127) begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            dvd_reg <= {64'd0, cnr_pkg::magnitude(num)} << FRAC_BITS;
            md_reg  <= cnr_pkg::magnitude(den);
            neg_reg <= num[63] ^ den[63];
            r_reg   <= 64'd0;
            q_reg   <= 64'd0;
            ovf_reg <= 1'b0;
        end
        else if (run_reg) begin
            dvd_reg <= {dvd_reg[126:0], 1'b0};
            // a bit shifted out of the quotient means overflow
            ovf_reg <= ovf_reg | q_reg[63];
            q_reg   <= {q_reg[62:0], take};
            r_reg   <= take ? 64'(r_shift - {1'b0, md_reg}) : r_shift[63:0];
        end
        if (fin_reg) begin
            result_reg <= cnr_pkg::apply_sign(q_reg, neg_reg, ovf_reg);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### tb/tb_cubic_newton_root_solver_top.sv
// Self-checking testbench for the cubic Newton-Raphson root solver top level.
module tb_cubic_newton_root_solver_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 48;

    typedef struct packed {
        logic [63:0] c0;
        logic [63:0] c1;
        logic [63:0] c2;
        logic [63:0] c3;
        logic [63:0] x0;
    } cubic_t;

    typedef struct packed {
        logic [63:0] root;
        logic [63:0] resid;
        logic [15:0] steps;
        logic [1:0]  stat;
    } solution_t;

    // one directed row; chk set where the answer is typed in
    typedef struct {
        cubic_t    poly;
        logic      chk;
        solution_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [63:0] coef_zero, coef_one, coef_two, coef_three, start_guess;
    logic        done;
    logic [63:0] root, residual;
    logic [15:0] steps_taken;
    logic [1:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    cubic_newton_root_solver_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .coef_zero(coef_zero), .coef_one(coef_one), .coef_two(coef_two),
        .coef_three(coef_three), .start_guess(start_guess), .done(done),
        .root(root), .residual(residual), .steps_taken(steps_taken), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    logic [63:0] tol_q;
    logic [15:0] limit_q;
    logic [63:0] fail_q;
    solution_t   pending_roots[$];
    int          fail_count;
    bit          calm;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #1s;
        $display("cubic_newton_root_solver_top regression: fail");
        $finish;
    end

    function automatic logic [63:0] abs64(input logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] clamp(input logic [63:0] m, input logic neg,
                                          input logic ovf);
        if (neg)
            return (ovf || m > cnr_pkg::MIN_VAL) ? cnr_pkg::MIN_VAL : -m;
        return (ovf || m > cnr_pkg::MAX_VAL) ? cnr_pkg::MAX_VAL : m;
    endfunction

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > $signed({1'b0, cnr_pkg::MAX_VAL})) return cnr_pkg::MAX_VAL;
        if (s < $signed({1'b1, cnr_pkg::MIN_VAL})) return cnr_pkg::MIN_VAL;
        return s[63:0];
    endfunction

    function automatic logic [63:0] sub_sat(input logic [63:0] a, input logic [63:0] b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) - $signed({b[63], b});
        if (s > $signed({1'b0, cnr_pkg::MAX_VAL})) return cnr_pkg::MAX_VAL;
        if (s < $signed({1'b1, cnr_pkg::MIN_VAL})) return cnr_pkg::MIN_VAL;
        return s[63:0];
    endfunction

    function automatic logic [63:0] fmul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
        p = p >> FB;
        return clamp(p[63:0], a[63] ^ b[63], |p[127:64]);
    endfunction

    function automatic logic [63:0] fdiv(input logic [63:0] n, input logic [63:0] d);
        logic [127:0] q;
        q = ({64'd0, abs64(n)} << FB) / {64'd0, abs64(d)};
        return clamp(q[63:0], n[63] ^ d[63], |q[127:64]);
    endfunction

    function automatic logic [63:0] eval_poly(input cubic_t c, input logic [63:0] x);
        logic [63:0] x2, x3, s;
        x2 = fmul(x, x);
        x3 = fmul(x2, x);
        s = add_sat(c.c0, fmul(c.c1, x));
        s = add_sat(s, fmul(c.c2, x2));
        return add_sat(s, fmul(c.c3, x3));
    endfunction

    function automatic logic [63:0] eval_slope(input cubic_t c, input logic [63:0] x);
        logic [63:0] x2, t, u;
        x2 = fmul(x, x);
        t = fmul(c.c2, x);
        u = fmul(c.c3, x2);
        return add_sat(add_sat(c.c1, add_sat(t, t)), add_sat(add_sat(u, u), u));
    endfunction

    function automatic solution_t solve_cubic(input cubic_t c);
        solution_t   r;
        logic [63:0] x, e, dp;
        logic [15:0] n;
        bit          flat;
        x = c.x0;
        n = 0;
        flat = 0;
        e = eval_poly(c, x);
        while (abs64(e) > tol_q && n < limit_q) begin
            dp = eval_slope(c, x);
            if (dp == 0) begin
                flat = 1;
                break;
            end
            x = sub_sat(x, fdiv(e, dp));
            e = eval_poly(c, x);
            n++;
        end
        r.root = x;
        r.resid = e;
        r.steps = n;
        if (flat) r.stat = cnr_pkg::ST_FLAT;
        else if (n >= limit_q)
            r.stat = (abs64(e) > fail_q) ? cnr_pkg::ST_FAILED : cnr_pkg::ST_LIMIT_OK;
        else r.stat = cnr_pkg::ST_CONVERGED;
        return r;
    endfunction

    // compare each result against the oldest expectation
    always @(posedge clk)
    begin
        solution_t w;
        if (rst_n && done) begin
            if (pending_roots.size() == 0) begin
                $error("unexpected result root=%h", root);
                fail_count++;
            end
            else begin
                w = pending_roots.pop_front();
                if (root !== w.root) begin
                    $error("root exp %h got %h", w.root, root);
                    fail_count++;
                end
                if (residual !== w.resid) begin
                    $error("residual exp %h got %h", w.resid, residual);
                    fail_count++;
                end
                if (steps_taken !== w.steps) begin
                    $error("steps_taken exp %0d got %0d", w.steps, steps_taken);
                    fail_count++;
                end
                if (status !== w.stat) begin
                    $error("status exp %0d got %0d", w.stat, status);
                    fail_count++;
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            cnr_pkg::CFG_TOLERANCE:  tol_q = {32'd0, val};
            cnr_pkg::CFG_STEP_LIMIT: limit_q = val[15:0];
            cnr_pkg::CFG_FAIL:       fail_q = {32'd0, val};
            default: ;
        endcase
    endtask

    // start stays up after a transfer; the block is busy then, so the next
    // item simply waits on the lines
    task automatic send_cubic(input cubic_t c, input bit chk, input solution_t typed);
        solution_t w;
        while (!calm && $urandom_range(99) < 27) begin
            start <= 1'b0;
            @(posedge clk);
        end
        w = solve_cubic(c);
        if (chk && w !== typed) begin
            $error("table row disagrees with prediction: %h vs %h", typed, w);
            fail_count++;
        end
        start <= 1'b1;
        coef_zero <= c.c0;
        coef_one <= c.c1;
        coef_two <= c.c2;
        coef_three <= c.c3;
        start_guess <= c.x0;
        do @(posedge clk); while (busy);
        pending_roots.push_back(chk ? typed : w);
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_roots.size() != 0 && guard < 20000000) begin
            @(posedge clk);
            guard++;
        end
        repeat (50) @(posedge clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] fix(input int v);
        return 64'(longint'(v)) << FB;
    endfunction

    // a cubic with a known real root near a small integer
    function automatic cubic_t rnd_cubic();
        cubic_t c;
        int     r;
        r = $urandom_range(8) - 4;
        c.c3 = fix($urandom_range(4) - 2);
        if (c.c3 == 0) c.c3 = fix(1);
        c.c2 = fix($urandom_range(6) - 3);
        c.c1 = fix($urandom_range(10) - 5);
        c.c0 = sub_sat(0, add_sat(add_sat(fmul(c.c1, fix(r)), fmul(c.c2, fix(r * r))),
                                  fmul(c.c3, fix(r * r * r))));
        c.x0 = fix(r) + {30'd0, 2'($urandom_range(3)), $urandom} - (64'd1 << 49);
        return c;
    endfunction

    row_t        dir_rows[$];
    row_t        rw;
    cubic_t      c;
    solution_t   s0;

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = cnr_pkg::CFG_TOLERANCE;
        cfg_data = '0;
        {coef_zero, coef_one, coef_two, coef_three, start_guess} = '0;
        fail_count = 0;
        calm = 0;
        tol_q = cnr_pkg::TOL_RESET;
        limit_q = cnr_pkg::LIMIT_RESET;
        fail_q = cnr_pkg::FAIL_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero polynomial: residual already zero
        rw.poly = '0; rw.chk = 1; rw.want = '{0, 0, 0, cnr_pkg::ST_CONVERGED};
        dir_rows.push_back(rw);
        // constant nonzero: derivative is zero at once
        rw.poly = '{fix(1), 0, 0, 0, fix(3)};
        rw.want = '{fix(3), fix(1), 0, cnr_pkg::ST_FLAT};
        dir_rows.push_back(rw);
        rw.poly = '{cnr_pkg::MIN_VAL, 0, 0, 0, cnr_pkg::MAX_VAL};
        rw.want = '{cnr_pkg::MAX_VAL, cnr_pkg::MIN_VAL, 0, cnr_pkg::ST_FLAT};
        dir_rows.push_back(rw);
        rw.chk = 0;
        rw.poly = '{-fix(2), 0, 0, fix(1), fix(1)}; dir_rows.push_back(rw);
        rw.poly = '{fix(6), -fix(5), 0, fix(1), -fix(3)}; dir_rows.push_back(rw);
        rw.poly = '{cnr_pkg::MAX_VAL, cnr_pkg::MAX_VAL, cnr_pkg::MAX_VAL, cnr_pkg::MAX_VAL,
                    cnr_pkg::MAX_VAL};
        dir_rows.push_back(rw);
        rw.poly = '{cnr_pkg::MIN_VAL, cnr_pkg::MIN_VAL, cnr_pkg::MIN_VAL, cnr_pkg::MIN_VAL,
                    cnr_pkg::MIN_VAL};
        dir_rows.push_back(rw);
        rw.poly = '{cnr_pkg::MAX_VAL, cnr_pkg::MIN_VAL, 1, -1, cnr_pkg::MIN_VAL};
        dir_rows.push_back(rw);
        rw.poly = '{-fix(1), 0, fix(1), 0, 0}; dir_rows.push_back(rw);
        rw.poly = '{fix(1), 0, fix(1), 0, fix(1)}; dir_rows.push_back(rw);
        rw.poly = '{1, 1, 1, 1, 1}; dir_rows.push_back(rw);
        rw.poly = '{-1, -1, -1, -1, -1}; dir_rows.push_back(rw);
        foreach (dir_rows[i]) send_cubic(dir_rows[i].poly, dir_rows[i].chk, dir_rows[i].want);
        drain();

        // step limit of one: status 1 or 2 against a zero fail threshold
        write_reg(cnr_pkg::CFG_STEP_LIMIT, 32'd1);
        write_reg(cnr_pkg::CFG_FAIL, 32'd0);
        write_reg(cnr_pkg::CFG_TOLERANCE, 32'hFFFF_FFFF);
        s0 = '0;
        send_cubic('{-fix(2), 0, 0, fix(1), fix(1)}, 0, s0);
        drain();
        write_reg(cnr_pkg::CFG_TOLERANCE, 32'd0);
        send_cubic('{-fix(2), 0, 0, fix(1), fix(1)}, 0, s0);
        send_cubic('{fix(6), -fix(5), 0, fix(1), -fix(3)}, 0, s0);
        drain();
        write_reg(cnr_pkg::CFG_STEP_LIMIT, 32'd0);
        write_reg(cnr_pkg::CFG_FAIL, 32'hFFFF_FFFF);
        send_cubic('{fix(5), 0, 0, fix(1), 0}, 1, '{0, fix(5), 0, cnr_pkg::ST_FAILED});
        send_cubic('{1, 0, 0, fix(1), 0}, 1, '{0, 1, 0, cnr_pkg::ST_LIMIT_OK});
        drain();

        for (int k = 0; k < 600; k++) begin
            if (k % 100 == 0) begin
                drain();
                case ((k / 100) % 4)
                    0: begin
                        write_reg(cnr_pkg::CFG_TOLERANCE, cnr_pkg::TOL_RESET);
                        write_reg(cnr_pkg::CFG_STEP_LIMIT, 32'd20);
                        write_reg(cnr_pkg::CFG_FAIL, cnr_pkg::FAIL_RESET);
                    end
                    1: begin
                        write_reg(cnr_pkg::CFG_TOLERANCE, 32'd0);
                        write_reg(cnr_pkg::CFG_STEP_LIMIT, $urandom_range(1, 6));
                        write_reg(cnr_pkg::CFG_FAIL, $urandom);
                    end
                    2: begin
                        write_reg(cnr_pkg::CFG_TOLERANCE, 32'hFFFF_FFFF);
                        write_reg(cnr_pkg::CFG_STEP_LIMIT, $urandom_range(41, 200));
                        write_reg(cnr_pkg::CFG_FAIL, 32'hFFFF_FFFF);
                    end
                    default: begin
                        write_reg(cnr_pkg::CFG_TOLERANCE, $urandom_range(1000));
                        write_reg(cnr_pkg::CFG_STEP_LIMIT, $urandom_range(2, 30));
                        write_reg(cnr_pkg::CFG_FAIL, $urandom);
                    end
                endcase
                // drop idling for a stretch
                calm = (k == 300);
            end
            if ($urandom_range(9) < 8) c = rnd_cubic();
            else c = '{rnd64(), rnd64(), rnd64(), rnd64(), rnd64()};
            // bound the run when the limit is high and noise would wander
            if (limit_q > 40) c = rnd_cubic();
            send_cubic(c, 0, s0);
        end
        drain();
        if (fail_count == 0 && pending_roots.size() == 0)
            $display("cubic_newton_root_solver_top regression: pass");
        else
            $display("cubic_newton_root_solver_top regression: fail");
        $finish;
    end
endmodule
